@@ design/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescape / UTF-8 unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_CLOSED = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_UNTERMINATED = 2'd0;
    localparam logic [1:0] ERR_INCOMPLETE   = 2'd1;
    localparam logic [1:0] ERR_ILLEGAL      = 2'd2;
    localparam logic [1:0] ERR_BAD_UNICODE  = 2'd3;

    // Most result words one input word can produce
    localparam int RES_MAX = 6;

    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_HEX1    = 3'd2,
        MODE_HIGH    = 3'd3,
        MODE_HIGH_BS = 3'd4,
        MODE_HEX2    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
    } res_t;

    // Batch of results from one input word
    typedef struct packed {
        logic [2:0]                cnt;
        res_t [RES_MAX-1:0]        ent;
    } res_batch_t;

endpackage

@@ design/jsu_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channels: raw text words in, decoded result words out.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output kind, output error_code,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    input last, output ready);
endinterface

@@ design/jsu_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder state and one-word decode step; produces a result batch.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          in_byte,
    input  logic                text_end,
    output jsu_pkg::res_batch_t batch
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    typedef struct packed {
        logic [2:0]      cnt;
        logic [3:0][7:0] b;
    } u8_t;

    function automatic u8_t utf8(input logic [20:0] cp);
        u8_t r;
        r = '0;
        if (cp < 21'h80) begin
            r.cnt  = 3'd1;
            r.b[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h800) begin
            r.cnt  = 3'd2;
            r.b[0] = {3'b110, cp[10:6]};
            r.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h10000) begin
            r.cnt  = 3'd3;
            r.b[0] = {4'b1110, cp[15:12]};
            r.b[1] = {2'b10, cp[11:6]};
            r.b[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.cnt  = 3'd4;
            r.b[0] = {5'b11110, cp[20:18]};
            r.b[1] = {2'b10, cp[17:12]};
            r.b[2] = {2'b10, cp[11:6]};
            r.b[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic res_t mk(input logic [1:0] k, input logic [7:0] b,
                                input logic [1:0] e);
        res_t r;
        r.out_byte   = b;
        r.kind       = k;
        r.error_code = e;
        return r;
    endfunction

    // State: pending high surrogate kept as its low 10 bits (top is 110110)
    mode_t       mode_reg,  mode_next;
    logic [11:0] accum_reg, accum_next;
    logic [1:0]  count_reg, count_next;
    logic [9:0]  pend_reg,  pend_next;

    logic        hex_ok;
    logic [3:0]  hex_d;
    logic        esc_ok;
    logic [7:0]  esc_val;
    logic [15:0] v;
    logic        v_high;
    logic        v_low;
    u8_t         u8_v;
    u8_t         u8_pair;
    logic        emit_a;
    logic [2:0]  b_cnt;
    res_t [3:0]  b_ent;
    res_t [2:0]  a_ent;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = '0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_d = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_d = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_d = 4'(in_byte - 8'h37);
        else
            hex_ok = 1'b0;
        if (text_end)
            hex_ok = 1'b0;
    end

    always_comb
    begin
        esc_ok  = 1'b1;
        esc_val = '0;
        case (in_byte)
            CH_QUOTE: esc_val = CH_QUOTE;
            CH_BSL:   esc_val = CH_BSL;
            CH_SLASH: esc_val = CH_SLASH;
            CH_B:     esc_val = 8'h08;
            CH_F:     esc_val = 8'h0C;
            CH_N:     esc_val = 8'h0A;
            CH_R:     esc_val = 8'h0D;
            CH_T:     esc_val = 8'h09;
            default:  esc_ok  = 1'b0;
        endcase
    end

    assign v       = {accum_reg, hex_d};
    assign v_high  = (v[15:10] == 6'b110110);
    assign v_low   = (v[15:10] == 6'b110111);
    assign u8_v    = utf8({5'd0, v});
    assign u8_pair = utf8(21'h10000 + {1'b0, pend_reg, v[9:0]});

    // Pending high surrogate as 3-byte UTF-8
    assign a_ent[0] = mk(KIND_BYTE, {4'b1110, 4'hD}, ERR_UNTERMINATED);
    assign a_ent[1] = mk(KIND_BYTE, {4'b1010, pend_reg[9:6]}, ERR_UNTERMINATED);
    assign a_ent[2] = mk(KIND_BYTE, {2'b10, pend_reg[5:0]}, ERR_UNTERMINATED);

    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        emit_a     = 1'b0;
        b_cnt      = '0;
        b_ent      = '0;

        unique case (mode_reg)
            MODE_ESC, MODE_HIGH_BS:
            begin
                if (mode_reg == MODE_HIGH_BS && !(text_end == 1'b0 && in_byte == CH_U))
                    emit_a = 1'b1;
                pend_next = '0;
                if (text_end) begin
                    b_cnt    = 3'd1;
                    b_ent[0] = mk(KIND_ERROR, 8'd0, ERR_INCOMPLETE);
                    mode_next  = MODE_PLAIN;
                    accum_next = '0;
                    count_next = '0;
                end
                else if (in_byte == CH_U) begin
                    accum_next = '0;
                    count_next = '0;
                    pend_next  = pend_reg;
                    mode_next  = (mode_reg == MODE_HIGH_BS) ? MODE_HEX2 : MODE_HEX1;
                end
                else if (esc_ok) begin
                    b_cnt     = 3'd1;
                    b_ent[0]  = mk(KIND_BYTE, esc_val, ERR_UNTERMINATED);
                    mode_next = MODE_PLAIN;
                end
                else begin
                    b_cnt    = 3'd1;
                    b_ent[0] = mk(KIND_ERROR, 8'd0, ERR_ILLEGAL);
                    mode_next  = MODE_PLAIN;
                    accum_next = '0;
                    count_next = '0;
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (!hex_ok) begin
                    emit_a     = (mode_reg == MODE_HEX2);
                    b_cnt      = 3'd1;
                    b_ent[0]   = mk(KIND_ERROR, 8'd0, ERR_BAD_UNICODE);
                    mode_next  = MODE_PLAIN;
                    accum_next = '0;
                    count_next = '0;
                    pend_next  = '0;
                end
                else if (count_reg != 2'd3) begin
                    accum_next = v[11:0];
                    count_next = count_reg + 2'd1;
                end
                else if (mode_reg == MODE_HEX2 && v_low) begin
                    b_cnt = u8_pair.cnt;
                    for (int i = 0; i < 4; i++)
                        b_ent[i] = mk(KIND_BYTE, u8_pair.b[i], ERR_UNTERMINATED);
                    mode_next  = MODE_PLAIN;
                    accum_next = '0;
                    count_next = '0;
                    pend_next  = '0;
                end
                else begin
                    // Fresh code; an unpaired high goes out first
                    emit_a     = (mode_reg == MODE_HEX2);
                    accum_next = '0;
                    count_next = '0;
                    if (v_high) begin
                        pend_next = v[9:0];
                        mode_next = MODE_HIGH;
                    end
                    else begin
                        pend_next = '0;
                        b_cnt     = u8_v.cnt;
                        for (int i = 0; i < 4; i++)
                            b_ent[i] = mk(KIND_BYTE, u8_v.b[i], ERR_UNTERMINATED);
                        mode_next = MODE_PLAIN;
                    end
                end
            end
            default:
            begin
                // Plain text, and waiting-high which behaves the same once flushed
                if (mode_reg == MODE_HIGH && !(text_end == 1'b0 && in_byte == CH_BSL))
                    emit_a = 1'b1;
                if (text_end) begin
                    b_cnt      = 3'd1;
                    b_ent[0]   = mk(KIND_ERROR, 8'd0, ERR_UNTERMINATED);
                    mode_next  = MODE_PLAIN;
                    accum_next = '0;
                    count_next = '0;
                    pend_next  = '0;
                end
                else if (in_byte == CH_BSL) begin
                    mode_next = (mode_reg == MODE_HIGH) ? MODE_HIGH_BS : MODE_ESC;
                end
                else if (in_byte == CH_QUOTE) begin
                    b_cnt      = 3'd1;
                    b_ent[0]   = mk(KIND_CLOSED, 8'd0, ERR_UNTERMINATED);
                    mode_next  = MODE_PLAIN;
                    accum_next = '0;
                    count_next = '0;
                    pend_next  = '0;
                end
                else begin
                    b_cnt     = 3'd1;
                    b_ent[0]  = mk(KIND_BYTE, in_byte, ERR_UNTERMINATED);
                    mode_next = MODE_PLAIN;
                    pend_next = '0;
                end
            end
        endcase
    end

    // Concatenate flushed high surrogate and main results
    always_comb
    begin
        logic [2:0] off;
        logic [2:0] j;
        off       = emit_a ? 3'd3 : 3'd0;
        batch.cnt = off + b_cnt;
        for (int i = 0; i < RES_MAX; i++) begin
            j = 3'(i) - off;
            if (emit_a && i < 3)
                batch.ent[i] = a_ent[i];
            else if (j < 3'd4)
                batch.ent[i] = b_ent[j[1:0]];
            else
                batch.ent[i] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_PLAIN;
            accum_reg <= '0;
            count_reg <= '0;
            pend_reg  <= '0;
        end
        else if (take) begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

@@ design/jsu_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_buf
// Result register: holds one batch and sends its words one per cycle while res.ready is high.
// ----------------------------------------------------------------------------
module jsu_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jsu_pkg::res_batch_t batch,
    output logic                free,
    jsu_out_if.source           res
);
    import jsu_pkg::*;

    res_t [RES_MAX-1:0] ent_reg;
    logic [2:0]         cnt_reg, cnt_next;
    logic [2:0]         idx_reg, idx_next;
    logic               fire;

    assign res.valid      = (idx_reg != cnt_reg);
    assign fire           = res.valid && res.ready;
    assign free           = !res.valid || (fire && (idx_reg + 3'd1 == cnt_reg));
    assign res.out_byte   = ent_reg[idx_reg].out_byte;
    assign res.kind       = ent_reg[idx_reg].kind;
    assign res.error_code = ent_reg[idx_reg].error_code;
    assign res.last       = (idx_reg + 3'd1 == cnt_reg);

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load) begin
            cnt_next = batch.cnt;
            idx_next = '0;
        end
        else if (fire) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= batch.ent;
    end

endmodule

@@ design/json_string_unescape_utf8_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_unit
// Decodes a JSON string body to UTF-8 bytes, closed mark or error.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word fields                          Role
//  text      in   in_byte[7:0], text_end               raw body bytes / end mark
//  decoded   out  out_byte[7:0], kind[1:0],            decoded bytes, closed,
//                 error_code[1:0], last                errors
//
//  Cycles: one input word per cycle while it yields at most one result word
//  and the output is ready. A word that yields n results (up to 6, e.g. a
//  flushed high surrogate plus a 3-byte code) holds the input until the result
//  register, which drains one word per cycle when not stalled, has sent them;
//  the next word is taken in the cycle the last result leaves.
//  Reset: rst_n (async, low) returns to plain text with nothing pending.
//  Stalls: output backpressure only; no bubbles between batches.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     text,
    jsu_out_if.source  decoded
);
    import jsu_pkg::*;

    res_batch_t batch;
    logic       take;
    logic       free;

    // Input taken whenever the result register is empty or finishing
    assign text.ready = free;
    assign take       = text.valid && text.ready;

    // Escape / surrogate state and one-word decode
    jsu_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_byte  (text.in_byte),
        .text_end (text.text_end),
        .batch    (batch)
    );

    // Result register and serializer
    jsu_out_buf u_out_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (take),
        .batch (batch),
        .free  (free),
        .res   (decoded)
    );

`ifndef SYNTHESIS
    // A word with results shows a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        take && (batch.cnt != 3'd0) |=> decoded.valid)
        else $error("result missing after accepted word");

    // Closed and error words always end their batch
    assert property (@(posedge clk) disable iff (!rst_n)
        decoded.valid && (decoded.kind != KIND_BYTE) |-> decoded.last)
        else $error("closed/error word not last");

    // Empty result register never blocks input
    assert property (@(posedge clk) disable iff (!rst_n)
        !decoded.valid |-> text.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

@@ dv/json_unescape_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_unescape_checker
// Watches the text and decoded channels, predicts the decoded words of every
// accepted text word and compares them in order with what the unit emits.
// ----------------------------------------------------------------------------
module json_unescape_checker (
    input  logic clk,
    input  logic rst_n,
    jsu_in_if    text,
    jsu_out_if   decoded,
    output int   fail_count,
    output int   words_pending
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] error_code;
        logic       last;
    } decoded_word_t;

    // Decoder state as seen from outside
    mode_t       dec_mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [15:0] high_sur;

    decoded_word_t batch[$];
    decoded_word_t expected_decoded[$];
    int            result_idx;

    function automatic void reset_decoder();
        dec_mode = MODE_PLAIN;
        hex_acc  = '0;
        hex_cnt  = '0;
        high_sur = '0;
    endfunction

    function automatic void push_word(input logic [1:0] k, input logic [7:0] b,
                                      input logic [1:0] e);
        decoded_word_t w;
        w = '{out_byte: b, kind: k, error_code: e, last: 1'b0};
        batch.insert(batch.size(), w);
    endfunction

    function automatic void push_error(input logic [1:0] code);
        push_word(KIND_ERROR, 8'h00, code);
        reset_decoder();
    endfunction

    function automatic void push_utf8(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            push_word(KIND_BYTE, cp[7:0], ERR_UNTERMINATED);
        end
        else if (cp < 21'h800)
        begin
            push_word(KIND_BYTE, 8'hC0 | {3'b000, cp[10:6]}, ERR_UNTERMINATED);
            push_word(KIND_BYTE, 8'h80 | {2'b00, cp[5:0]}, ERR_UNTERMINATED);
        end
        else if (cp < 21'h10000)
        begin
            push_word(KIND_BYTE, 8'hE0 | {4'h0, cp[15:12]}, ERR_UNTERMINATED);
            push_word(KIND_BYTE, 8'h80 | {2'b00, cp[11:6]}, ERR_UNTERMINATED);
            push_word(KIND_BYTE, 8'h80 | {2'b00, cp[5:0]}, ERR_UNTERMINATED);
        end
        else
        begin
            push_word(KIND_BYTE, 8'hF0 | {5'h00, cp[20:18]}, ERR_UNTERMINATED);
            push_word(KIND_BYTE, 8'h80 | {2'b00, cp[17:12]}, ERR_UNTERMINATED);
            push_word(KIND_BYTE, 8'h80 | {2'b00, cp[11:6]}, ERR_UNTERMINATED);
            push_word(KIND_BYTE, 8'h80 | {2'b00, cp[5:0]}, ERR_UNTERMINATED);
        end
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9)
            return int'(c) - int'(CH_0);
        if (c >= CH_LOW_A && c <= CH_LOW_F)
            return int'(c) - int'(CH_LOW_A) + 10;
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c) - int'(CH_UP_A) + 10;
        return -1;
    endfunction

    // Finished first \u value: a high surrogate waits, anything else is emitted
    function automatic void take_code(input logic [15:0] v);
        hex_acc = '0;
        hex_cnt = '0;
        if (v >= 16'hD800 && v <= 16'hDBFF)
        begin
            high_sur = v;
            dec_mode = MODE_HIGH;
        end
        else
        begin
            high_sur = '0;
            push_utf8({5'b0, v});
            dec_mode = MODE_PLAIN;
        end
    endfunction

    function automatic void plain_byte(input logic [7:0] c);
        if (c == CH_QUOTE)
        begin
            push_word(KIND_CLOSED, 8'h00, ERR_UNTERMINATED);
            reset_decoder();
        end
        else if (c == CH_BSLASH)
        begin
            dec_mode = MODE_ESC;
        end
        else
        begin
            push_word(KIND_BYTE, c, ERR_UNTERMINATED);
            dec_mode = MODE_PLAIN;
        end
    endfunction

    function automatic void escape_char(input logic [7:0] c);
        logic [7:0] b;
        case (c)
            CH_QUOTE:  b = CH_QUOTE;
            CH_BSLASH: b = CH_BSLASH;
            CH_SLASH:  b = CH_SLASH;
            CH_LOW_B:  b = 8'h08;
            CH_LOW_F:  b = 8'h0C;
            CH_LOW_N:  b = 8'h0A;
            CH_LOW_R:  b = 8'h0D;
            CH_LOW_T:  b = 8'h09;
            CH_LOW_U:
            begin
                hex_acc  = '0;
                hex_cnt  = '0;
                dec_mode = MODE_HEX1;
                return;
            end
            default:
            begin
                push_error(ERR_ILLEGAL);
                return;
            end
        endcase
        push_word(KIND_BYTE, b, ERR_UNTERMINATED);
        dec_mode = MODE_PLAIN;
    endfunction

    // Expected decoded words for one accepted text word
    function automatic void decode_text_word(input logic [7:0] c, input logic fin);
        int          d;
        logic [15:0] v;
        logic [20:0] cp;
        batch.delete();
        case (dec_mode)
            MODE_ESC:
            begin
                if (fin)
                    push_error(ERR_INCOMPLETE);
                else
                    escape_char(c);
            end
            MODE_HEX1, MODE_HEX2:
            begin
                d = fin ? -1 : hex_value(c);
                if (d < 0)
                begin
                    if (dec_mode == MODE_HEX2)
                        push_utf8({5'b0, high_sur});
                    push_error(ERR_BAD_UNICODE);
                end
                else
                begin
                    v = {hex_acc[11:0], 4'(d)};
                    if (hex_cnt < 2'd3)
                    begin
                        hex_acc = v;
                        hex_cnt = hex_cnt + 2'd1;
                    end
                    else if (dec_mode == MODE_HEX1)
                    begin
                        take_code(v);
                    end
                    else if (v >= 16'hDC00 && v <= 16'hDFFF)
                    begin
                        cp = 21'h10000 + ((21'(high_sur) - 21'hD800) << 10)
                             + (21'(v) - 21'hDC00);
                        push_utf8(cp);
                        reset_decoder();
                    end
                    else
                    begin
                        push_utf8({5'b0, high_sur});
                        take_code(v);
                    end
                end
            end
            MODE_HIGH:
            begin
                if (fin)
                begin
                    push_utf8({5'b0, high_sur});
                    push_error(ERR_UNTERMINATED);
                end
                else if (c == CH_BSLASH)
                begin
                    dec_mode = MODE_HIGH_BS;
                end
                else
                begin
                    push_utf8({5'b0, high_sur});
                    high_sur = '0;
                    plain_byte(c);
                end
            end
            MODE_HIGH_BS:
            begin
                if (fin)
                begin
                    push_utf8({5'b0, high_sur});
                    push_error(ERR_INCOMPLETE);
                end
                else if (c == CH_LOW_U)
                begin
                    hex_acc  = '0;
                    hex_cnt  = '0;
                    dec_mode = MODE_HEX2;
                end
                else
                begin
                    push_utf8({5'b0, high_sur});
                    high_sur = '0;
                    escape_char(c);
                end
            end
            default:
            begin
                if (fin)
                    push_error(ERR_UNTERMINATED);
                else
                    plain_byte(c);
            end
        endcase
        if (batch.size() > 0)
            batch[$].last = 1'b1;
        foreach (batch[i])
            expected_decoded.insert(expected_decoded.size(), batch[i]);
    endfunction

    function automatic void note_failure(input string what, input decoded_word_t got,
                                         input decoded_word_t want);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s at result %0d: ", $realtime, what, result_idx,
                     "exp byte=%h kind=%0d err=%0d last=%b, ",
                     want.out_byte, want.kind, want.error_code, want.last,
                     "got byte=%h kind=%0d err=%0d last=%b",
                     got.out_byte, got.kind, got.error_code, got.last);
    endfunction

    initial
    begin
        reset_decoder();
        fail_count    = 0;
        words_pending = 0;
        result_idx    = 0;
    end

    always @(posedge clk)
    begin : monitor
        decoded_word_t got;
        decoded_word_t want;
        if (rst_n)
        begin
            // Predict before comparing so the queue is current
            if (text.valid && text.ready)
                decode_text_word(text.in_byte, text.text_end);
            if (decoded.valid && decoded.ready)
            begin
                got = '{out_byte: decoded.out_byte, kind: decoded.kind,
                        error_code: decoded.error_code, last: decoded.last};
                if (expected_decoded.size() == 0)
                begin
                    note_failure("unexpected word", got, '0);
                end
                else
                begin
                    want = expected_decoded.pop_front();
                    if (got !== want)
                        note_failure("mismatch", got, want);
                end
                result_idx++;
            end
            words_pending <= expected_decoded.size();
        end
    end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the JSON string unescape unit. A short directed
// sequence is followed by random string bodies, mostly well formed (plain
// bytes, escapes, \u codes, surrogate pairs) with broken escapes, stray
// surrogates and early text ends mixed in. Both channels idle at random, except in the full-rate phase.
// ----------------------------------------------------------------------------
module tb;
    import jsu_pkg::*;

    // Characters used to build string bodies
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_Q  = 8'h71;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_LOW_A  = 8'h61;

    // Random text words after the directed part, split over three idle phases
    localparam int RANDOM_WORDS = 390;
    // Cycles with no handshake on either channel before giving up.
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    jsu_in_if  text_ch ();
    jsu_out_if decoded_ch ();

    int fail_count;
    int words_pending;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;

    json_string_unescape_utf8_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .decoded (decoded_ch)
    );

    json_unescape_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .text          (text_ch),
        .decoded       (decoded_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Receiver: ready drops at random with the current phase's idle rate
    always @(posedge clk)
    begin
        decoded_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one text word, with random idle cycles ahead of it, and hold it
    // until the unit takes it. valid stays high between back-to-back words.
    task automatic send_word(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid    <= 1'b1;
        text_ch.in_byte  <= b;
        text_ch.text_end <= fin;
        @(posedge clk);
        while (!text_ch.ready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // End of text: in_byte is don't-care, so it gets a random value
    task automatic send_end();
        send_word(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46)
               || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
            return CH_0 + 8'(nib);
        // either case is legal in a \u escape
        if ($urandom_range(1))
            return CH_UP_A + 8'(nib) - 8'd10;
        return CH_LOW_A + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] pick_simple_escape();
        case ($urandom_range(7))
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_LOW_B;
            4:       return CH_LOW_F;
            5:       return CH_LOW_N;
            6:       return CH_LOW_R;
            default: return CH_LOW_T;
        endcase
    endfunction

    function automatic logic [7:0] pick_illegal_escape();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_LOW_B
               || b == CH_LOW_F || b == CH_LOW_N || b == CH_LOW_R || b == CH_LOW_T
               || b == CH_LOW_U);
        return b;
    endfunction

    // Code point outside the surrogate range, spread over the 1- to 3-byte UTF-8 lengths
    function automatic logic [15:0] pick_code();
        logic [15:0] v;
        case ($urandom_range(3))
            0: v = 16'($urandom_range(16'h007F));
            1: v = 16'($urandom_range(16'h07FF, 16'h0080));
            2:
            begin
                do
                    v = 16'($urandom_range(16'hFFFF, 16'h0800));
                while (v >= 16'hD800 && v <= 16'hDFFF);
            end
            default:
            begin
                case ($urandom_range(7))
                    0:       v = 16'h0000;
                    1:       v = 16'h007F;
                    2:       v = 16'h0080;
                    3:       v = 16'h07FF;
                    4:       v = 16'h0800;
                    5:       v = 16'hD7FF;
                    6:       v = 16'hE000;
                    default: v = 16'hFFFF;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic [15:0] pick_high();
        return 16'($urandom_range(16'hDBFF, 16'hD800));
    endfunction

    function automatic logic [15:0] pick_low();
        return 16'($urandom_range(16'hDFFF, 16'hDC00));
    endfunction

    task automatic send_u_escape(input logic [15:0] v);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_LOW_U, 1'b0);
        send_word(hex_char(v[15:12]), 1'b0);
        send_word(hex_char(v[11:8]), 1'b0);
        send_word(hex_char(v[7:4]), 1'b0);
        send_word(hex_char(v[3:0]), 1'b0);
    endtask

    // \u cut short after 0..3 digits by a non-hex byte or the end of text
    task automatic send_bad_u();
        int         good;
        logic [7:0] b;
        good = $urandom_range(3);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_LOW_U, 1'b0);
        repeat (good)
        begin
            send_word(hex_char(4'($urandom_range(15))), 1'b0);
        end
        if ($urandom_range(3) == 0)
        begin
            send_end();
        end
        else
        begin
            do
                b = 8'($urandom_range(255));
            while (is_hex(b));
            send_word(b, 1'b0);
        end
    endtask

    // What follows a high surrogate that does not get its low partner
    task automatic send_after_high();
        case ($urandom_range(7))
            0: send_word(pick_plain_byte(), 1'b0);
            1: send_word(CH_QUOTE, 1'b0);
            2:
            begin
                send_word(CH_BSLASH, 1'b0);
                send_word(pick_simple_escape(), 1'b0);
            end
            3: send_u_escape($urandom_range(1) ? pick_high() : pick_code());
            4: send_bad_u();
            5: send_end();
            6:
            begin
                send_word(CH_BSLASH, 1'b0);
                send_end();
            end
            default:
            begin
                send_word(CH_BSLASH, 1'b0);
                send_word(pick_illegal_escape(), 1'b0);
            end
        endcase
    endtask

    // One random piece of a string body; mostly legal text
    task automatic send_random_piece();
        int sel;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            send_word(pick_plain_byte(), 1'b0);
        end
        else if (sel < 50)
        begin
            send_word(CH_BSLASH, 1'b0);
            send_word(pick_simple_escape(), 1'b0);
        end
        else if (sel < 65)
        begin
            send_u_escape(pick_code());
        end
        else if (sel < 75)
        begin
            send_u_escape(pick_high());
            send_u_escape(pick_low());
        end
        else if (sel < 82)
        begin
            send_u_escape(pick_high());
            send_after_high();
        end
        else if (sel < 85)
        begin
            // lone low surrogate goes out as plain 3-byte UTF-8
            send_u_escape(pick_low());
        end
        else if (sel < 90)
        begin
            send_word(CH_QUOTE, 1'b0);
        end
        else if (sel < 92)
        begin
            send_end();
        end
        else if (sel < 95)
        begin
            send_word(CH_BSLASH, 1'b0);
            send_word(pick_illegal_escape(), 1'b0);
        end
        else if (sel < 98)
        begin
            send_bad_u();
        end
        else if (sel < 99)
        begin
            send_word(CH_BSLASH, 1'b0);
            send_end();
        end
        else
        begin
            // raw noise, quote and backslash included
            send_word(8'($urandom_range(255)), 1'b0);
        end
    endtask

    // Watchdog: stop when neither channel has moved a word for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((text_ch.valid && text_ch.ready) || (decoded_ch.valid && decoded_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int target;
        text_ch.valid    = 1'b0;
        text_ch.in_byte  = 8'h00;
        text_ch.text_end = 1'b0;
        decoded_ch.ready = 1'b0;
        rst_n            = 1'b0;
        items_sent       = 0;
        send_idle_pct    = 33;
        recv_idle_pct    = 61;

        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme raw bytes and the closing quote
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        // Simple escape, then text ending in plain mode
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_LOW_N, 1'b0);
        send_word(8'hFF, 1'b1);
        // Surrogate pair joined into a 4-byte code, then unterminated end
        send_u_escape(16'hD83D);
        send_u_escape(16'hDE00);
        send_word(8'h00, 1'b1);
        // Illegal escape character
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_LOW_Q, 1'b0);
        // Text ending right after a backslash
        send_word(CH_BSLASH, 1'b0);
        send_word(8'h00, 1'b1);

        // Random part in three idle phases: receiver-heavy stalls is phase 0,
        // sender-heavy gaps is phase 1, full rate is phase 2
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 33;
                    recv_idle_pct = 61;
                end
                1:
                begin
                    send_idle_pct = 61;
                    recv_idle_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = items_sent + RANDOM_WORDS / 3;
            while (items_sent < target)
            begin
                send_random_piece();
            end
        end
        text_ch.valid <= 1'b0;

        // The pending count is registered behind the checker's queue, so let it update
        // before trusting it, then wait for the last decoded word to leave.
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        if (fail_count == 0 && words_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
